// ===== rtl/lhfe_pkg.sv =====
// Shared types and constants for the LED hue and intensity fade engine.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package lhfe_pkg;

   localparam int LEDS    = 32;
   localparam int HUE_MAX = 1535;

   localparam int CMD_W  = 3;
   localparam int LED_W  = 5;
   localparam int HUE_W  = 11;
   localparam int LVL_W  = 8;
   localparam int RING_W = HUE_W + 1;
   localparam int IDX_W  = (LEDS > 1) ? $clog2(LEDS) : 1;
   localparam int CNT_W  = $clog2(LEDS + 1);
   localparam int CMP_W  = 7;

   localparam logic [HUE_W-1:0]  HUE_MAX_V = HUE_W'(HUE_MAX);
   localparam logic [RING_W-1:0] RING_V    = RING_W'(HUE_MAX + 1);

   localparam logic [CMD_W-1:0] CMD_SET_HUE_LVL = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_LVL     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LATCH_DIR   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK        = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SWITCH      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SNAP        = 3'd5;

   typedef enum logic [2:0] {
      OP_SET,
      OP_LATCH,
      OP_TICK,
      OP_SWITCH,
      OP_SNAP,
      OP_EMIT
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic             up;
      logic [LVL_W-1:0] tgt_lvl;
      logic [HUE_W-1:0] tgt_hue;
      logic [LVL_W-1:0] cur_lvl;
      logic [HUE_W-1:0] cur_hue;
   } entry_type;

   typedef struct packed {
      logic             req_load;
      op_type           op;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic             last;
   } ctl_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/lhfe_ctrl.sv =====
// Controller of the fade engine: command decode, walk sequencer and read pipeline control.
// Depends on lhfe_pkg; drives the datapath through a command struct.
`default_nettype none
module lhfe_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [lhfe_pkg::CMD_W-1:0] req_command,
   input  wire logic [lhfe_pkg::LED_W-1:0] req_led_index,
   input  wire logic                       out_free,
   output lhfe_pkg::ctl_cmd_type           cmd
);
   import lhfe_pkg::*;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic             single_ff, single_in;
   logic [LED_W-1:0] led_idx_ff, led_idx_in;
   logic [CNT_W-1:0] iss_cnt_ff, iss_cnt_in;
   logic             s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0] s1_addr_ff, s1_addr_in;

   logic             accept;
   logic             start;
   op_type           start_op;
   logic             start_single;
   logic             walk;
   logic             emit_pass;
   logic             consume;
   logic             advance;
   logic             more;
   logic             done;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_en;

   always_comb begin
      start        = 1'b0;
      start_op     = OP_SET;
      start_single = 1'b0;
      unique case (req_command)
         CMD_SET_HUE_LVL, CMD_SET_LVL: begin
            start        = (CMP_W'(req_led_index) < CMP_W'(LEDS));
            start_single = 1'b1;
         end
         CMD_LATCH_DIR: begin
            start    = 1'b1;
            start_op = OP_LATCH;
         end
         CMD_TICK: begin
            start    = 1'b1;
            start_op = OP_TICK;
         end
         CMD_SWITCH: begin
            start    = 1'b1;
            start_op = OP_SWITCH;
         end
         CMD_SNAP: begin
            start    = 1'b1;
            start_op = OP_SNAP;
         end
         default: begin
            start = 1'b0;
         end
      endcase
   end

   always_comb begin
      walk      = (state_ff == ST_WALK);
      accept    = (state_ff == ST_IDLE) && req_tvalid;
      emit_pass = (op_ff == OP_SWITCH) || (op_ff == OP_EMIT);
      consume   = walk && s1_vld_ff && (!emit_pass || out_free);
      advance   = !s1_vld_ff || consume;
      more      = single_ff ? (iss_cnt_ff == '0) : (iss_cnt_ff < CNT_W'(LEDS));
      done      = walk && !more && (!s1_vld_ff || consume);
      rd_addr   = single_ff ? IDX_W'(led_idx_ff) : iss_cnt_ff[IDX_W-1:0];
      rd_en     = walk && advance && more;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && start) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (done && (op_ff != OP_TICK)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      cmd.req_load = accept;
      cmd.op       = op_ff;
      cmd.rd_en    = rd_en;
      cmd.rd_addr  = rd_addr;
      cmd.wr_en    = consume;
      cmd.wr_addr  = s1_addr_ff;
      cmd.last     = (s1_addr_ff == IDX_W'(LEDS - 1));
   end

   always_comb begin
      op_in      = op_ff;
      single_in  = single_ff;
      led_idx_in = led_idx_ff;
      iss_cnt_in = iss_cnt_ff;
      s1_vld_in  = s1_vld_ff;
      s1_addr_in = s1_addr_ff;
      if (accept) begin
         op_in      = start_op;
         single_in  = start_single;
         led_idx_in = req_led_index;
         iss_cnt_in = '0;
         s1_vld_in  = 1'b0;
      end else if (walk) begin
         if (done && (op_ff == OP_TICK)) begin
            op_in      = OP_EMIT;
            single_in  = 1'b0;
            iss_cnt_in = '0;
            s1_vld_in  = 1'b0;
         end else begin
            if (rd_en) begin
               iss_cnt_in = iss_cnt_ff + CNT_W'(1);
               s1_addr_in = rd_addr;
            end
            if (advance) begin
               s1_vld_in = more;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         op_ff      <= OP_SET;
         single_ff  <= 1'b0;
         iss_cnt_ff <= '0;
         s1_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         op_ff      <= op_in;
         single_ff  <= single_in;
         iss_cnt_ff <= iss_cnt_in;
         s1_vld_ff  <= s1_vld_in;
      end
      led_idx_ff <= led_idx_in;
      s1_addr_ff <= s1_addr_in;
   end

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !s1_vld_ff)
      else $error("read stage holds an item while idle");

   a_addr_apart: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && cmd.wr_en) |-> (cmd.rd_addr != cmd.wr_addr))
      else $error("read and write hit the same entry in one cycle");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      iss_cnt_ff <= CNT_W'(LEDS))
      else $error("walk counter ran past the last LED");

endmodule
`default_nettype wire

// ===== rtl/lhfe_datapath.sv =====
// Datapath of the fade engine: entry memory, per-entry update logic and result register.
// Depends on lhfe_pkg; controlled by lhfe_ctrl through a command struct.
`default_nettype none
module lhfe_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lhfe_pkg::ctl_cmd_type      cmd,
   input  wire logic [lhfe_pkg::CMD_W-1:0] req_command,
   input  wire logic [lhfe_pkg::HUE_W-1:0] req_hue,
   input  wire logic [lhfe_pkg::LVL_W-1:0] req_intensity,
   input  wire logic                       req_force_all,
   output logic                            out_free,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [lhfe_pkg::LED_W-1:0]      rsp_led_out,
   output logic [lhfe_pkg::HUE_W-1:0]      rsp_hue_out,
   output logic [lhfe_pkg::LVL_W-1:0]      rsp_intensity_out,
   output logic                            rsp_touched_out,
   output logic                            rsp_settled,
   output logic                            rsp_last
);
   import lhfe_pkg::*;

   entry_type        mem [LEDS];
   logic [LEDS-1:0]  valid_ff;
   logic [LEDS-1:0]  dirty_ff;
   entry_type        rd_raw_ff;
   logic             rd_vld_ff;

   logic [HUE_W-1:0] hue_ff;
   logic [LVL_W-1:0] lvl_ff;
   logic             hue_en_ff;
   logic             force_ff;
   logic             same_ff, same_in;

   logic             out_vld_ff, out_vld_in;
   logic [LED_W-1:0] out_led_ff;
   logic [HUE_W-1:0] out_hue_ff;
   logic [LVL_W-1:0] out_lvl_ff;
   logic             out_touch_ff;
   logic             out_settled_ff;
   logic             out_last_ff;

   entry_type         cur;
   entry_type         nxt;
   logic              mark;
   logic              change;
   logic              emit;
   logic              dirty_now;
   logic [RING_W-1:0] a_ext;
   logic [RING_W-1:0] b_ext;
   logic [RING_W-1:0] hue_gap;
   logic              shorter;

   always_comb begin
      cur       = rd_vld_ff ? rd_raw_ff : '0;
      dirty_now = dirty_ff[cmd.wr_addr];
      emit      = (cmd.op == OP_SWITCH) || (cmd.op == OP_EMIT);
      nxt       = cur;
      mark      = 1'b0;
      change    = 1'b0;
      a_ext     = RING_W'(cur.cur_hue);
      b_ext     = RING_W'(cur.tgt_hue);
      hue_gap   = (a_ext > b_ext) ? (a_ext - b_ext) : (b_ext - a_ext);
      shorter   = ((RING_V - hue_gap) > hue_gap);
      unique case (cmd.op)
         OP_SET: begin
            if (hue_en_ff && (cur.cur_hue != hue_ff)) begin
               nxt.tgt_hue = hue_ff;
               mark        = 1'b1;
            end
            if (cur.cur_lvl != lvl_ff) begin
               nxt.tgt_lvl = lvl_ff;
               mark        = 1'b1;
            end
         end
         OP_LATCH: begin
            nxt.up = (a_ext > b_ext) ? !shorter : shorter;
         end
         OP_TICK: begin
            if (cur.cur_hue != cur.tgt_hue) begin
               change = 1'b1;
               if (cur.up) begin
                  nxt.cur_hue = (cur.cur_hue < HUE_MAX_V) ?
                                (cur.cur_hue + HUE_W'(1)) : '0;
               end else begin
                  nxt.cur_hue = (cur.cur_hue != '0) ?
                                (cur.cur_hue - HUE_W'(1)) : HUE_MAX_V;
               end
            end
            if (cur.cur_lvl != cur.tgt_lvl) begin
               change = 1'b1;
               if (cur.tgt_lvl > cur.cur_lvl) begin
                  nxt.cur_lvl = cur.cur_lvl + LVL_W'(1);
               end else begin
                  nxt.cur_lvl = cur.cur_lvl - LVL_W'(1);
               end
            end
            mark = change;
         end
         OP_SWITCH: begin
            nxt.cur_hue = cur.tgt_hue;
            nxt.cur_lvl = cur.tgt_lvl;
         end
         OP_SNAP: begin
            nxt.cur_hue = cur.tgt_hue;
            mark        = 1'b1;
         end
         OP_EMIT: begin
            nxt = cur;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= nxt;
      end
      if (cmd.rd_en) begin
         rd_raw_ff <= mem[cmd.rd_addr];
         rd_vld_ff <= valid_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.wr_addr] <= 1'b1;
         if (emit) begin
            dirty_ff[cmd.wr_addr] <= 1'b0;
         end else if (mark) begin
            dirty_ff[cmd.wr_addr] <= 1'b1;
         end
      end
   end

   always_comb begin
      same_in = same_ff;
      if (cmd.req_load) begin
         same_in = 1'b1;
      end else if (cmd.wr_en && (cmd.op == OP_TICK) && change) begin
         same_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         hue_ff    <= (req_hue > HUE_MAX_V) ? HUE_MAX_V : req_hue;
         lvl_ff    <= req_intensity;
         hue_en_ff <= (req_command == CMD_SET_HUE_LVL);
         force_ff  <= req_force_all;
      end
      same_ff <= same_in;
   end

   always_comb begin
      out_free   = !out_vld_ff || rsp_tready;
      out_vld_in = out_vld_ff && !rsp_tready;
      if (cmd.wr_en && emit) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      if (cmd.wr_en && emit) begin
         out_led_ff     <= LED_W'(cmd.wr_addr);
         out_hue_ff     <= nxt.cur_hue;
         out_lvl_ff     <= nxt.cur_lvl;
         out_touch_ff   <= dirty_now || ((cmd.op == OP_SWITCH) && force_ff);
         out_settled_ff <= (cmd.op == OP_EMIT) && same_ff;
         out_last_ff    <= cmd.last;
      end
   end

   assign rsp_tvalid        = out_vld_ff;
   assign rsp_led_out       = out_led_ff;
   assign rsp_hue_out       = out_hue_ff;
   assign rsp_intensity_out = out_lvl_ff;
   assign rsp_touched_out   = out_touch_ff;
   assign rsp_settled       = out_settled_ff;
   assign rsp_last          = out_last_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && emit) |-> out_free)
      else $error("result loaded while the previous item is still waiting");

   a_dirty_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && emit) |=> !dirty_ff[$past(cmd.wr_addr)])
      else $error("touched mark survived a reported entry");

   a_not_settled: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && (cmd.op == OP_TICK) && change && !cmd.req_load) |=> !same_ff)
      else $error("settled flag kept after an entry changed");

endmodule
`default_nettype wire

// ===== rtl/led_hue_intensity_fade_engine.sv =====
// Set commands update a single LED; latch and snap walk every LED, one LED per cycle.
// Switch streams LEDS results, one per cycle unless rsp_tready holds the output back.
// Tick steps all LEDS, then streams LEDS results.
// One entry is read and one entry written per cycle, unless a waiting result stalls the walk.
// Synchronous reset clears control state and the valid and touched bits; all
// entries then read as zero, with no clearing pass.
`default_nettype none
module led_hue_intensity_fade_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // Fields from bit 0: command[2:0], led_index[7:3], hue[18:8], intensity[26:19].
   input  wire logic [31:0] req_tdata,
   // Fields from bit 0: force_all[0].
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // Fields from bit 0: led_out[4:0], hue_out[15:5], intensity_out[23:16].
   output logic [23:0]      rsp_tdata,
   // Fields from bit 0: touched_out[0], settled[1].
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);
   import lhfe_pkg::*;

   ctl_cmd_type      cmd;
   logic             out_free;
   logic [CMD_W-1:0] req_command;
   logic [LED_W-1:0] req_led_index;
   logic [HUE_W-1:0] req_hue;
   logic [LVL_W-1:0] req_intensity;
   logic [LED_W-1:0] rsp_led_out;
   logic [HUE_W-1:0] rsp_hue_out;
   logic [LVL_W-1:0] rsp_intensity_out;
   logic             rsp_touched_out;
   logic             rsp_settled;

   assign req_command   = req_tdata[2:0];
   assign req_led_index = req_tdata[7:3];
   assign req_hue       = req_tdata[18:8];
   assign req_intensity = req_tdata[26:19];

   lhfe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_command   (req_command),
      .req_led_index (req_led_index),
      .out_free      (out_free),
      .cmd           (cmd)
   );

   lhfe_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_command       (req_command),
      .req_hue           (req_hue),
      .req_intensity     (req_intensity),
      .req_force_all     (req_tuser),
      .out_free          (out_free),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_led_out       (rsp_led_out),
      .rsp_hue_out       (rsp_hue_out),
      .rsp_intensity_out (rsp_intensity_out),
      .rsp_touched_out   (rsp_touched_out),
      .rsp_settled       (rsp_settled),
      .rsp_last          (rsp_tlast)
   );

   assign rsp_tdata = {rsp_intensity_out, rsp_hue_out, rsp_led_out};
   assign rsp_tuser = {rsp_settled, rsp_touched_out};

endmodule
`default_nettype wire
